@@ rtl/assert_macros.svh @@
// Assertion macros shared by the tile map collision RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TMRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TMRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/tmrc_pkg.sv @@
// Package for the tile map collision block: map geometry, index widths,
// the tile range struct and the map address function. Depends on nothing.
`default_nettype none

package tmrc_pkg;

    localparam int TILE_PIXELS = 32;
    localparam int TILE_SHIFT  = $clog2(TILE_PIXELS);
    localparam int GRID_COLS   = 32;
    localparam int GRID_ROWS   = 32;
    localparam int MAP_DEPTH   = GRID_COLS * GRID_ROWS;

    localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    localparam int COORD_W = 16;
    localparam int WIDX_W  = 5;
    localparam int CODE_W  = 8;
    localparam int IN_W    = 120;
    localparam int OUT_W   = 24;

    typedef struct packed {
        logic             empty;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
    } t_range;

    function automatic logic [ADDR_W-1:0] map_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

@@ rtl/tile_map_rect_collision.sv @@
// Top level of the tile map collision block: the tile map memory and the scan sequencer.
// Depends on tmrc_pkg, tmrc_box_range and assert_macros.svh.
//
//  Channel  Direction  Beat contents
//  s_axis   in         tuser: mode; tdata: box geometry or one tile write
//  m_axis   out        tdata: hit code, column and row, one beat per query
//
// A tile write gives no beat. A query scans the map tiles up to the first hit through the
// single map read port, one tile per cycle; a query whose range misses the map reads none.
// Reset clears the sequencer and the output valid; the map is undefined until written.
// New beats are taken while a finished result waits on m_axis; a stalled result holds the
// next query in its final cycle.
`default_nettype none

module tile_map_rect_collision (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_x, pos_y, box_left, box_top, box_right, box_bottom, write_col, write_row,
    // write_code, zero fill
    input  logic [tmrc_pkg::IN_W-1:0]  s_axis_tdata,
    // mode
    input  logic [0:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // hit_code, hit_col, hit_row, zero fill
    output logic [tmrc_pkg::OUT_W-1:0] m_axis_tdata
);
    import tmrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   r_rd_vld, n_rd_vld;

    logic [COL_W-1:0]  r_col, n_col, r_c0, n_c0, r_c1, n_c1;
    logic [ROW_W-1:0]  r_row, n_row, r_r1, n_r1;
    logic [COL_W-1:0]  r_rd_col, n_rd_col, r_res_col, n_res_col;
    logic [ROW_W-1:0]  r_rd_row, n_rd_row, r_res_row, n_res_row;
    logic [CODE_W-1:0] r_res_code, n_res_code;
    logic [CODE_W-1:0] r_out_code, n_out_code;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [CODE_W-1:0] r_rd_data;

    logic [CODE_W-1:0] r_map [MAP_DEPTH];

    logic [WIDX_W-1:0] in_wcol;
    logic [WIDX_W-1:0] in_wrow;
    logic [CODE_W-1:0] in_wcode;
    logic              in_beat;
    logic              in_mode;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_hit;
    t_range            range;

    tmrc_box_range u_range (
        .i_pos_x      (s_axis_tdata[15:0]),
        .i_pos_y      (s_axis_tdata[31:16]),
        .i_box_left   (s_axis_tdata[47:32]),
        .i_box_top    (s_axis_tdata[63:48]),
        .i_box_right  (s_axis_tdata[79:64]),
        .i_box_bottom (s_axis_tdata[95:80]),
        .o_range      (range)
    );

    assign in_wcol  = s_axis_tdata[100:96];
    assign in_wrow  = s_axis_tdata[105:101];
    assign in_wcode = s_axis_tdata[113:106];
    assign in_mode  = s_axis_tuser[0];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign wr_en   = in_beat && !in_mode && (int'(in_wcol) < GRID_COLS)
                     && (int'(in_wrow) < GRID_ROWS);
    assign wr_addr = map_addr(ROW_W'(in_wrow), COL_W'(in_wcol));
    assign rd_addr = map_addr(r_row, r_col);
    assign rd_hit  = r_rd_vld && (r_rd_data != '0);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(OUT_W - CODE_W - 2 * WIDX_W)'(0), WIDX_W'(r_out_row),
                            WIDX_W'(r_out_col), r_out_code};

    always_comb begin
        n_state    = r_state;
        n_m_valid  = r_m_valid;
        n_rd_vld   = 1'b0;
        n_col      = r_col;
        n_row      = r_row;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_r1       = r_r1;
        n_rd_col   = r_col;
        n_rd_row   = r_row;
        n_res_code = r_res_code;
        n_res_col  = r_res_col;
        n_res_row  = r_res_row;
        n_out_code = r_out_code;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        rd_en      = 1'b0;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_beat && in_mode) begin
                    n_c0  = range.c0;
                    n_c1  = range.c1;
                    n_r1  = range.r1;
                    n_col = range.c0;
                    n_row = range.r0;
                    if (range.empty) begin
                        n_res_code = '0;
                        n_res_col  = '0;
                        n_res_row  = '0;
                        n_state    = ST_RESULT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_hit) begin
                    n_res_code = r_rd_data;
                    n_res_col  = r_rd_col;
                    n_res_row  = r_rd_row;
                    n_state    = ST_RESULT;
                end else begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    if (r_col == r_c1) begin
                        n_col = r_c0;
                        n_row = r_row + ROW_W'(1);
                        if (r_row == r_r1) begin
                            n_state = ST_WAIT;
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            ST_WAIT: begin
                if (rd_hit) begin
                    n_res_code = r_rd_data;
                    n_res_col  = r_rd_col;
                    n_res_row  = r_rd_row;
                end else begin
                    n_res_code = '0;
                    n_res_col  = '0;
                    n_res_row  = '0;
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_out_code = r_res_code;
                    n_out_col  = r_res_col;
                    n_out_row  = r_res_row;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_rd_vld  <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_row      <= n_row;
        r_c0       <= n_c0;
        r_c1       <= n_c1;
        r_r1       <= n_r1;
        r_rd_col   <= n_rd_col;
        r_rd_row   <= n_rd_row;
        r_res_code <= n_res_code;
        r_res_col  <= n_res_col;
        r_res_row  <= n_res_row;
        r_out_code <= n_out_code;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= in_wcode;
        end
        if (rd_en) begin
            r_rd_data <= r_map[rd_addr];
        end
    end

`include "assert_macros.svh"

    `TMRC_ASSERT(a_scan_in_range, (r_state == ST_SCAN) |-> (r_col >= r_c0 && r_col <= r_c1 && r_row <= r_r1), "scan position left the tile range")
    `TMRC_ASSERT(a_read_only_in_scan, r_rd_vld |-> (r_state == ST_SCAN || r_state == ST_WAIT), "map read data outside a scan")
    `TMRC_ASSERT(a_wait_has_read, (r_state == ST_WAIT) |-> r_rd_vld, "final scan cycle without a pending map read")
    `TMRC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!m_axis_tvalid && r_state == ST_IDLE), "reset left the sequencer busy")

endmodule

`default_nettype wire

@@ rtl/tmrc_box_range.sv @@
// Works out the clipped tile range that a query box covers on the map.
// Depends on tmrc_pkg for the tile size, the grid size and t_range.
`default_nettype none

module tmrc_box_range (
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_box_left,
    input  logic signed [15:0] i_box_top,
    input  logic signed [15:0] i_box_right,
    input  logic signed [15:0] i_box_bottom,
    output tmrc_pkg::t_range   o_range
);
    import tmrc_pkg::*;

    localparam logic signed [17:0] COLS_S = 18'(GRID_COLS);
    localparam logic signed [17:0] ROWS_S = 18'(GRID_ROWS);

    logic signed [17:0] left_e;
    logic signed [17:0] top_e;
    logic signed [17:0] right_m1;
    logic signed [17:0] bottom_m1;
    logic signed [17:0] fl_c;
    logic signed [17:0] fh_c;
    logic signed [17:0] fl_r;
    logic signed [17:0] fh_r;
    logic               empty_c;
    logic               empty_r;

    assign left_e    = 18'(i_pos_x) + 18'(i_box_left);
    assign top_e     = 18'(i_pos_y) + 18'(i_box_top);
    assign right_m1  = 18'(i_pos_x) + 18'(i_box_right) - 18'sd1;
    assign bottom_m1 = 18'(i_pos_y) + 18'(i_box_bottom) - 18'sd1;

    assign fl_c = left_e >>> TILE_SHIFT;
    assign fh_c = right_m1 >>> TILE_SHIFT;
    assign fl_r = top_e >>> TILE_SHIFT;
    assign fh_r = bottom_m1 >>> TILE_SHIFT;

    assign empty_c = (fl_c > fh_c) || (fh_c < 18'sd0) || (fl_c >= COLS_S);
    assign empty_r = (fl_r > fh_r) || (fh_r < 18'sd0) || (fl_r >= ROWS_S);

    always_comb begin
        o_range.empty = empty_c || empty_r;
        o_range.c0    = (fl_c < 18'sd0) ? '0 : COL_W'(fl_c);
        o_range.c1    = (fh_c >= COLS_S) ? COL_W'(GRID_COLS - 1) : COL_W'(fh_c);
        o_range.r0    = (fl_r < 18'sd0) ? '0 : ROW_W'(fl_r);
        o_range.r1    = (fh_r >= ROWS_S) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(fh_r);
    end

endmodule

`default_nettype wire

@@ dv/tb_tile_map_rect_collision.sv @@
// Self-checking testbench for tile_map_rect_collision: fills the tile map, then runs directed and
// random tile writes and box queries, predicting each hit and comparing it beat by beat.
// Depends on tmrc_pkg and the tile_map_rect_collision RTL.
`default_nettype none

module tb_tile_map_rect_collision;

    timeunit 1ns;
    timeprecision 1ps;

    import tmrc_pkg::*;

    localparam bit MODE_WRITE = 1'b0;
    localparam bit MODE_QUERY = 1'b1;
    localparam int SETTLE_CYCLES = MAP_DEPTH + 100;
    localparam int LONG_HOLD_CYCLES = 600;

    typedef struct {
        bit                  mode;
        bit signed [15:0]    pos_x;
        bit signed [15:0]    pos_y;
        bit signed [15:0]    box_left;
        bit signed [15:0]    box_top;
        bit signed [15:0]    box_right;
        bit signed [15:0]    box_bottom;
        bit [WIDX_W-1:0]     write_col;
        bit [WIDX_W-1:0]     write_row;
        bit [CODE_W-1:0]     write_code;
    } t_tile_cmd;

    typedef struct {
        bit [CODE_W-1:0] code;
        bit [WIDX_W-1:0] col;
        bit [WIDX_W-1:0] row;
    } t_tile_hit;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    t_tile_cmd   cmd_queue[$];
    t_tile_hit   expected_hits[$];
    bit [7:0]    tile_codes[MAP_DEPTH];
    t_tile_cmd   cmd_on_bus;
    t_tile_cmd   next_cmd;
    t_tile_hit   seen_hit;
    t_tile_hit   want_hit;
    logic        in_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int          n_errors = 0;

    tile_map_rect_collision dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clip(int v, int lo, int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Scans the covered tile range row by row and returns the first nonzero tile that the box
    // strictly overlaps.
    function automatic t_tile_hit first_hit(t_tile_cmd q);
        int left, top, right, bottom;
        int c0, c1, r0, r1, tl, tt;
        t_tile_hit h;
        h = '{default: 0};
        left   = int'(q.pos_x) + int'(q.box_left);
        top    = int'(q.pos_y) + int'(q.box_top);
        right  = int'(q.pos_x) + int'(q.box_right);
        bottom = int'(q.pos_y) + int'(q.box_bottom);
        c0 = clip(left >>> TILE_SHIFT, 0, GRID_COLS);
        c1 = clip((right - 1) >>> TILE_SHIFT, -1, GRID_COLS - 1);
        r0 = clip(top >>> TILE_SHIFT, 0, GRID_ROWS);
        r1 = clip((bottom - 1) >>> TILE_SHIFT, -1, GRID_ROWS - 1);
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                tl = c * TILE_PIXELS;
                tt = r * TILE_PIXELS;
                if (tile_codes[r * GRID_COLS + c] != 0 && right > tl && left < tl + TILE_PIXELS
                    && bottom > tt && top < tt + TILE_PIXELS) begin
                    h.code = tile_codes[r * GRID_COLS + c];
                    h.col  = WIDX_W'(c);
                    h.row  = WIDX_W'(r);
                    return h;
                end
            end
        end
        return h;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = cmd_queue.pop_front();
                cmd_on_bus    <= next_cmd;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_cmd.mode;
                s_axis_tdata  <= {6'd0, next_cmd.write_code, next_cmd.write_row,
                                  next_cmd.write_col, next_cmd.box_bottom, next_cmd.box_right,
                                  next_cmd.box_top, next_cmd.box_left, next_cmd.pos_y,
                                  next_cmd.pos_x};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
            m_axis_tready  <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_hit.code = m_axis_tdata[7:0];
                seen_hit.col  = m_axis_tdata[12:8];
                seen_hit.row  = m_axis_tdata[17:13];
                if (expected_hits.size() == 0) begin
                    $error("result beat with no query outstanding: %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want_hit = expected_hits.pop_front();
                    if (seen_hit.code != want_hit.code) begin
                        $error("hit_code: expected %0d, got %0d", want_hit.code, seen_hit.code);
                        n_errors++;
                    end
                    if (seen_hit.col != want_hit.col) begin
                        $error("hit_col: expected %0d, got %0d", want_hit.col, seen_hit.col);
                        n_errors++;
                    end
                    if (seen_hit.row != want_hit.row) begin
                        $error("hit_row: expected %0d, got %0d", want_hit.row, seen_hit.row);
                        n_errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (cmd_on_bus.mode == MODE_WRITE) begin
                    tile_codes[int'(cmd_on_bus.write_row) * GRID_COLS
                               + int'(cmd_on_bus.write_col)] = cmd_on_bus.write_code;
                end else begin
                    expected_hits.push_back(first_hit(cmd_on_bus));
                end
            end
        end
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    task automatic queue_write(int col, int row, int code);
        t_tile_cmd w;
        w.mode       = MODE_WRITE;
        w.pos_x      = 16'($urandom);
        w.pos_y      = 16'($urandom);
        w.box_left   = 16'($urandom);
        w.box_top    = 16'($urandom);
        w.box_right  = 16'($urandom);
        w.box_bottom = 16'($urandom);
        w.write_col  = WIDX_W'(col);
        w.write_row  = WIDX_W'(row);
        w.write_code = CODE_W'(code);
        cmd_queue.push_back(w);
    endtask

    task automatic queue_query(int px, int py, int l, int t, int r, int b);
        t_tile_cmd q;
        q.mode       = MODE_QUERY;
        q.pos_x      = 16'(px);
        q.pos_y      = 16'(py);
        q.box_left   = 16'(l);
        q.box_top    = 16'(t);
        q.box_right  = 16'(r);
        q.box_bottom = 16'(b);
        q.write_col  = WIDX_W'($urandom);
        q.write_row  = WIDX_W'($urandom);
        q.write_code = CODE_W'($urandom);
        cmd_queue.push_back(q);
    endtask

    task automatic queue_random_cmd();
        int kind, px, py, l, t, r, b, tmp;
        kind = $urandom_range(99);
        if (kind < 25) begin
            queue_write($urandom_range(31), $urandom_range(31),
                        ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 255));
        end else if (kind < 29) begin
            queue_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            if (kind < 80) begin
                px = int'($urandom_range(1151)) - 64;
                py = int'($urandom_range(1151)) - 64;
            end else begin
                px = int'($urandom_range(6000)) - 3000;
                py = int'($urandom_range(6000)) - 3000;
            end
            l = int'($urandom_range(80)) - 40;
            t = int'($urandom_range(80)) - 40;
            r = l + int'($urandom_range(100)) - 4;
            b = t + int'($urandom_range(100)) - 4;
            if ($urandom_range(9) == 0) begin
                tmp = l;
                l = r;
                r = tmp;
            end
            queue_query(px, py, l, t, r, b);
        end
    endtask

    task automatic wait_all_done();
        @(negedge i_clk);
        while (cmd_queue.size() != 0 || s_axis_tvalid || expected_hits.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic run_random(int s_pct, int r_pct, int n_cmds);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n_cmds; i++) begin
            queue_random_cmd();
        end
        wait_all_done();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 76;
        for (int row = 0; row < GRID_ROWS; row++) begin
            for (int col = 0; col < GRID_COLS; col++) begin
                queue_write(col, row, ($urandom_range(99) < 15) ? $urandom_range(1, 255) : 0);
            end
        end
        wait_all_done();

        queue_write(0, 0, 255);
        queue_write(31, 31, 1);
        queue_write(31, 0, 128);
        queue_write(0, 31, 0);
        queue_query(0, 0, 0, 0, 32, 32);
        queue_query(992, 992, 0, 0, 32, 32);
        queue_query(-32768, -32768, 0, 0, 10, 10);
        queue_query(32767, 32767, 0, 0, 10, 10);
        queue_query(-16, -16, 0, 0, 32, 32);
        queue_query(0, 0, 0, 0, 0, 0);
        queue_query(5, 5, 0, 0, 0, 0);
        queue_query(0, 0, 40, 0, 10, 32);
        queue_query(0, 0, 20, 20, 10, 10);
        queue_query(0, 0, -32768, -32768, 32767, 32767);
        queue_query(32767, 32767, 32767, 32767, 32767, 32767);
        queue_query(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_query(-32768, -32768, 32767, 32767, 32767, 32767);
        queue_query(1000, 0, 0, 0, 24, 32);
        queue_query(0, 31, 0, 0, 32, 1);
        queue_query(-1, 0, 0, 0, 1, 32);
        queue_write(0, 31, 77);
        queue_query(0, 992, 0, 0, 32, 32);
        wait_all_done();

        run_random(8, 76, 100);
        run_random(76, 8, 100);
        long_hold_req = 1'b1;
        run_random(0, 0, 100);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_hits.size() == 0) begin
            $display("[tile_map_rect_collision] OK");
        end else begin
            $display("[tile_map_rect_collision] ERROR");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("[tile_map_rect_collision] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
